### design/drs_pkg.sv
// Shared types and constants of the disk request scheduler.
package drs_pkg;

    localparam int TRACK_W   = 11;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'b1;

    localparam logic [TRACK_W-1:0] TRACK_COUNT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_SSTF = 2'd1,
        POL_SCAN = 2'd2,
        POL_RSVD = 2'd3
    } policy_t;

    // One queue entry as it travels round the ring of cells.
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               served;
    } drs_entry_t;

    // Control of the candidate picker.
    typedef struct packed {
        logic clear;
        logic update;
        logic sstf;
    } drs_pick_ctl_t;

endpackage

### design/drs_req_if.sv
// Request channel: queue or schedule beats.
interface drs_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [drs_pkg::TRACK_W-1:0]  track;

    modport source (output valid, kind, track, input ready);
    modport sink   (input valid, kind, track, output ready);
endinterface

### design/drs_res_if.sv
// Result channel: served tracks in service order.
interface drs_res_if;
    logic                         valid;
    logic                         ready;
    logic [drs_pkg::TRACK_W-1:0]  served_track;
    logic                         last;
    logic                         empty_res;
    logic                         dropped;

    modport source (output valid, served_track, last, empty_res, dropped, input ready);
    modport sink   (input valid, served_track, last, empty_res, dropped, output ready);
endinterface

### design/drs_cfg_if.sv
// Configuration write channel.
interface drs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [drs_pkg::CFG_IDX_W-1:0]  index;
    logic [drs_pkg::TRACK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/drs_cell.sv
// One cell of the request ring: holds a queued track and its served mark.
module drs_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [drs_pkg::TRACK_W-1:0]  load_track,
    input  logic                         clear,
    input  logic                         shift,
    input  drs_pkg::drs_entry_t          from_next,
    output drs_pkg::drs_entry_t          entry
);

    logic [drs_pkg::TRACK_W-1:0] track_reg;
    logic [drs_pkg::TRACK_W-1:0] track_next;
    logic                        served_reg;
    logic                        served_next;

    always_comb
    begin
        track_next  = track_reg;
        served_next = served_reg;
        if (load)
        begin
            track_next  = load_track;
            served_next = 1'b0;
        end
        else if (shift)
        begin
            track_next  = from_next.track;
            served_next = from_next.served;
        end
        if (clear)
        begin
            served_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        track_reg <= track_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 1'b0;
        end
        else
        begin
            served_reg <= served_next;
        end
    end

    assign entry.track  = track_reg;
    assign entry.served = served_reg;

endmodule

### design/drs_pick.sv
// Candidate picker: watches the entries leaving the ring and keeps the next target.
module drs_pick (
    input  logic                         clk,
    input  logic                         rst_n,
    input  drs_pkg::drs_pick_ctl_t       ctl,
    input  logic [drs_pkg::TRACK_W-1:0]  cand_track,
    input  logic [drs_pkg::TRACK_W-1:0]  head_track,
    input  logic [drs_pkg::TRACK_W-1:0]  start_track,
    output logic [drs_pkg::TRACK_W-1:0]  next_track
);

    localparam int TW = drs_pkg::TRACK_W;

    // The best register doubles as the SSTF choice and the SCAN downward choice.
    logic [TW-1:0] best_reg,  best_next;
    logic [TW-1:0] bestd_reg, bestd_next;
    logic [TW-1:0] up_reg,    up_next;
    logic          have_reg,  have_next;
    logic          have_up_reg, have_up_next;
    logic [TW-1:0] seek_len;

    always_comb
    begin
        seek_len     = (cand_track > head_track) ? (cand_track - head_track)
                                                 : (head_track - cand_track);
        best_next    = best_reg;
        bestd_next   = bestd_reg;
        up_next      = up_reg;
        have_next    = have_reg;
        have_up_next = have_up_reg;
        if (ctl.clear)
        begin
            have_next    = 1'b0;
            have_up_next = 1'b0;
        end
        else if (ctl.update)
        begin
            if (ctl.sstf)
            begin
                // Equal distance goes to the later entry.
                if (!have_reg || seek_len <= bestd_reg)
                begin
                    best_next  = cand_track;
                    bestd_next = seek_len;
                    have_next  = 1'b1;
                end
            end
            else if (cand_track <= start_track)
            begin
                if (!have_reg || cand_track > best_reg)
                begin
                    best_next = cand_track;
                    have_next = 1'b1;
                end
            end
            else if (!have_up_reg || cand_track < up_reg)
            begin
                up_next      = cand_track;
                have_up_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
        up_reg    <= up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg    <= 1'b0;
            have_up_reg <= 1'b0;
        end
        else
        begin
            have_reg    <= have_next;
            have_up_reg <= have_up_next;
        end
    end

    assign next_track = (ctl.sstf || have_reg) ? best_reg : up_reg;

endmodule

### design/disk_request_scheduler_unit.sv
// Top level of the disk request scheduler: ring of request cells and pass sequencer.
//
//  Channel | Direction | Beat carries
//  --------+-----------+--------------------------------------------
//  req     | in        | kind, track
//  res     | out       | served_track, last, empty_res, dropped
//  cfg     | in        | index, data (track_count, policy_mode)
//
// A schedule beat runs one pass per distinct track served, a single pass in FIFO
// mode: the ring rotates all QUEUE_DEPTH cells past the evaluator at cell 0, then
// ST_NEXT picks the next target or ends the schedule. An empty schedule goes
// through ST_EMPTY and returns one result with empty_res set.
// Reset clears the queue count, served marks and overflow flag; no clearing pass.
// A stalled result beat freezes the ring; req is only ready between schedules.
module disk_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_TRACKS  = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    drs_req_if.sink   req,
    drs_res_if.source res,
    drs_cfg_if.sink   cfg
);

    localparam int TW    = drs_pkg::TRACK_W;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MT_W  = $clog2(MAX_TRACKS + 1);
    localparam int LW    = (MT_W > TW) ? MT_W : TW;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EMPTY = 4'b0010,
        ST_PASS  = 4'b0100,
        ST_NEXT  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TW-1:0]          track_count_reg, track_count_next;
    drs_pkg::policy_t       policy_reg, policy_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       served_cnt_reg, served_cnt_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic                   ovf_reg, ovf_next;
    logic [TW-1:0]          last_track_reg, last_track_next;
    logic [TW-1:0]          target_reg, target_next;

    logic                   out_valid_reg, out_valid_next;
    logic [TW-1:0]          out_track_reg, out_track_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_empty_reg, out_empty_next;
    logic                   out_drop_reg, out_drop_next;

    drs_pkg::drs_entry_t    cell_entry [QUEUE_DEPTH];
    drs_pkg::drs_entry_t    tail_entry;
    drs_pkg::drs_pick_ctl_t pick_ctl;
    logic [TW-1:0]          pick_track;

    logic                   req_fire;
    logic                   enq_ok;
    logic                   cell_clear;
    logic                   slot_free;
    logic                   step;
    logic                   head_valid;
    logic                   fifo_mode;
    logic                   match;
    logic [LW-1:0]          limit;
    logic [CNT_W-1:0]       served_plus;

    assign req.ready  = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign req_fire   = req.valid && req.ready;
    assign slot_free  = !out_valid_reg || res.ready;
    assign step       = (state_reg == ST_PASS) && slot_free;
    assign fifo_mode  = !(policy_reg == drs_pkg::POL_SSTF || policy_reg == drs_pkg::POL_SCAN);
    assign limit      = (LW'(track_count_reg) > LW'(MAX_TRACKS)) ? LW'(MAX_TRACKS)
                                                                 : LW'(track_count_reg);
    assign enq_ok     = req_fire && !req.kind && (req.track != '0)
                        && (LW'(req.track) <= limit) && (count_reg < CNT_W'(QUEUE_DEPTH));
    assign cell_clear = req_fire && req.kind;
    assign head_valid = {1'b0, pos_reg} < (IDX_W + 1)'(count_reg);
    assign match      = head_valid && !cell_entry[0].served
                        && (fifo_mode || cell_entry[0].track == target_reg);
    assign served_plus = served_cnt_reg + CNT_W'(1);

    // The entry leaving cell 0 re-enters at the tail with its mark updated.
    assign tail_entry.track  = cell_entry[0].track;
    assign tail_entry.served = cell_entry[0].served || match;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            drs_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (enq_ok && (count_reg[IDX_W-1:0] == IDX_W'(gi))),
                .load_track (req.track),
                .clear      (cell_clear),
                .shift      (step),
                .from_next  ((gi == QUEUE_DEPTH - 1) ? tail_entry
                                                     : cell_entry[(gi + 1) % QUEUE_DEPTH]),
                .entry      (cell_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        pick_ctl.sstf   = (policy_reg == drs_pkg::POL_SSTF);
        pick_ctl.update = step && head_valid && !cell_entry[0].served && !match;
        pick_ctl.clear  = cell_clear || (state_reg == ST_NEXT);
    end

    drs_pick u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (pick_ctl),
        .cand_track  (cell_entry[0].track),
        .head_track  (target_reg),
        .start_track (last_track_reg),
        .next_track  (pick_track)
    );

    always_comb
    begin
        state_next       = state_reg;
        track_count_next = track_count_reg;
        policy_next      = policy_reg;
        count_next       = count_reg;
        served_cnt_next  = served_cnt_reg;
        pos_next         = pos_reg;
        ovf_next         = ovf_reg;
        last_track_next  = last_track_reg;
        target_next      = target_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_track_next   = out_track_reg;
        out_last_next    = out_last_reg;
        out_empty_next   = out_empty_reg;
        out_drop_next    = out_drop_reg;

        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                drs_pkg::REG_TRACK_COUNT: track_count_next = cfg.data;
                drs_pkg::REG_POLICY_MODE: policy_next = drs_pkg::policy_t'(cfg.data[1:0]);
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (!req.kind)
                    begin
                        if (enq_ok)
                        begin
                            count_next      = count_reg + CNT_W'(1);
                            last_track_next = req.track;
                        end
                        else if (req.track != '0 && LW'(req.track) <= limit)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        served_cnt_next = '0;
                        pos_next        = '0;
                        target_next     = last_track_reg;
                        state_next      = ST_PASS;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_track_next = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    out_drop_next  = ovf_reg;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_PASS:
            begin
                if (step)
                begin
                    if (match)
                    begin
                        out_valid_next  = 1'b1;
                        out_track_next  = cell_entry[0].track;
                        out_last_next   = (served_plus == count_reg);
                        out_empty_next  = 1'b0;
                        out_drop_next   = ovf_reg;
                        served_cnt_next = served_plus;
                    end
                    if (pos_reg == IDX_W'(QUEUE_DEPTH - 1))
                    begin
                        pos_next   = '0;
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                end
            end
            ST_NEXT:
            begin
                if (served_cnt_reg == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    target_next = pick_track;
                    state_next  = ST_PASS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            track_count_reg <= drs_pkg::TRACK_COUNT_RESET;
            policy_reg      <= drs_pkg::POL_FIFO;
            count_reg       <= '0;
            served_cnt_reg  <= '0;
            pos_reg         <= '0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            track_count_reg <= track_count_next;
            policy_reg      <= policy_next;
            count_reg       <= count_next;
            served_cnt_reg  <= served_cnt_next;
            pos_reg         <= pos_next;
            ovf_reg         <= ovf_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_track_reg <= last_track_next;
        target_reg     <= target_next;
        out_track_reg  <= out_track_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_drop_reg   <= out_drop_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.served_track = out_track_reg;
    assign res.last         = out_last_reg;
    assign res.empty_res    = out_empty_reg;
    assign res.dropped      = out_drop_reg;

    // The ring must be back in arrival order whenever new requests can be loaded.
    a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pos_reg == '0))
        else $error("ring not aligned while idle");

    a_served_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS || state_reg == ST_NEXT) |-> (served_cnt_reg <= count_reg))
        else $error("more results than queued requests");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMPTY) |-> (count_reg == '0))
        else $error("empty result with requests queued");

    a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT && served_cnt_reg == count_reg) |=> (count_reg == '0))
        else $error("queue not emptied after batch");

endmodule
